[hw/rtl/adhc_pkg.sv]
// ----------------------------------------------------------------------------
// adhc_pkg
// Shared types, character codes and helpers for the ASCII decimal/hex
// converter: controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package adhc_pkg;

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'

   // offsets subtracted from a character to get its digit value
   localparam logic [31:0] DEC_OFFSET = 32'd48;
   localparam logic [31:0] HEX_OFFSET = 32'd55;

   // digit register: ten 4-bit digits
   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned DIG_W      = 4 * NUM_DIGITS;
   localparam int unsigned NDIG_W     = 4;
   localparam int unsigned BITCNT_W   = 5;
   localparam logic [BITCNT_W-1:0] BITCNT_LAST = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_BCD,
      ST_SKIP,
      ST_PFX0,
      ST_PFXX,
      ST_DIGIT
   } adhc_state_type;

   typedef enum logic [1:0] {
      EMIT_ZERO,
      EMIT_X,
      EMIT_DIGIT
   } adhc_emit_type;

   typedef struct packed {
      logic          step;      // take one input character
      logic          load;      // latch value into digit register, clear token
      logic          bcd_step;  // one shift-add-3 iteration
      logic          skip;      // drop one leading zero digit
      logic          emit;      // load one output beat
      adhc_emit_type emit_sel;
   } adhc_cmd_type;

   typedef struct packed {
      logic burst;       // accepted character closes a live token
      logic hex_mode;    // current token is hexadecimal
      logic out_dec;     // burst in progress produces decimal
      logic bcd_done;    // last conversion iteration this cycle
      logic skip_done;   // top digit significant or only one left
      logic out_free;    // output register can take a beat
      logic last_digit;  // top digit is the final one
   } adhc_status_type;

   // digit value to uppercase ASCII
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] ch;
      if (d <= 4'd9) begin
         ch = CHAR_ZERO + {4'd0, d};
      end else begin
         ch = CHAR_UPPER + {4'd0, d} - 8'd10;
      end
      return ch;
   endfunction

endpackage

[hw/rtl/adhc_datapath.sv]
// ----------------------------------------------------------------------------
// adhc_datapath
// Accumulator, token state, binary-to-BCD shifter, digit register and the
// output register of the converter. Acts on commands from adhc_ctrl.
// ----------------------------------------------------------------------------
module adhc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  adhc_pkg::adhc_cmd_type   cmd,
   output adhc_pkg::adhc_status_type status,
   input  logic [7:0]               req_char_byte,
   input  logic                     req_token_end,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_out_last,
   input  logic                     rsp_stall
);
   import adhc_pkg::*;

   logic [31:0]         acc_ff, acc_in;
   logic [1:0]          pos_ff, pos_in;
   logic                hex_ff, hex_in;
   logic                stopped_ff, stopped_in;
   logic [DIG_W-1:0]    dig_ff, dig_in;
   logic [31:0]         shift_ff, shift_in;
   logic [BITCNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [NDIG_W-1:0]   ndig_ff, ndig_in;
   logic                out_dec_ff, out_dec_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [31:0]      c32, dec_digit, hex_digit, acc_x10, acc_x16;
   logic [DIG_W-1:0] bcd_adj;
   logic [3:0]       top_digit;
   logic             out_free;

   // digit values of the incoming character
   assign c32       = {24'd0, req_char_byte};
   assign dec_digit = c32 - DEC_OFFSET;
   assign hex_digit = (req_char_byte >= CHAR_UPPER) ? (c32 - HEX_OFFSET) : dec_digit;
   assign acc_x10   = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0};
   assign acc_x16   = {acc_ff[27:0], 4'b0000};

   assign top_digit = dig_ff[DIG_W-1 -: 4];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // token accumulation
   always_comb begin
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      hex_in     = hex_ff;
      stopped_in = stopped_ff;
      if (cmd.load) begin
         acc_in = 32'd0;
         pos_in = 2'd0;
         hex_in = 1'b0;
      end else if (cmd.step && !stopped_ff) begin
         unique case (pos_ff)
            2'd0: begin
               if (req_char_byte == CHAR_MINUS) begin
                  stopped_in = 1'b1;
               end else begin
                  acc_in = dec_digit;
                  pos_in = 2'd1;
               end
            end
            2'd1: begin
               if (req_char_byte == CHAR_X) begin
                  hex_in = 1'b1;
                  acc_in = 32'd0;
               end else begin
                  acc_in = acc_x10 + dec_digit;
               end
               pos_in = 2'd2;
            end
            default: begin
               acc_in = hex_ff ? (acc_x16 + hex_digit) : (acc_x10 + dec_digit);
            end
         endcase
      end
   end

   // shift-add-3 adjust of every bcd digit
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ?
                             (dig_ff[4*i +: 4] + 4'd3) : dig_ff[4*i +: 4];
      end
   end

   // digit register, conversion and leading zero skip
   always_comb begin
      dig_in     = dig_ff;
      shift_in   = shift_ff;
      bitcnt_in  = bitcnt_ff;
      ndig_in    = ndig_ff;
      out_dec_in = out_dec_ff;
      if (cmd.load) begin
         dig_in     = hex_ff ? '0 : {{(DIG_W-32){1'b0}}, acc_ff};
         shift_in   = acc_ff;
         bitcnt_in  = '0;
         ndig_in    = NDIG_W'(NUM_DIGITS);
         out_dec_in = hex_ff;
      end else if (cmd.bcd_step) begin
         dig_in    = {bcd_adj[DIG_W-2:0], shift_ff[31]};
         shift_in  = {shift_ff[30:0], 1'b0};
         bitcnt_in = bitcnt_ff + 1'b1;
      end else if (cmd.skip || (cmd.emit && cmd.emit_sel == EMIT_DIGIT)) begin
         dig_in  = {dig_ff[DIG_W-5:0], 4'd0};
         ndig_in = ndig_ff - 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b0;
         unique case (cmd.emit_sel)
            EMIT_ZERO: rsp_char_in = CHAR_ZERO;
            EMIT_X:    rsp_char_in = CHAR_X;
            EMIT_DIGIT: begin
               rsp_char_in = digit_char(top_digit);
               rsp_last_in = (ndig_ff == NDIG_W'(1));
            end
            default:   rsp_char_in = CHAR_ZERO;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= '0;
         hex_ff       <= 1'b0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         hex_ff       <= hex_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      shift_ff    <= shift_in;
      bitcnt_ff   <= bitcnt_in;
      ndig_ff     <= ndig_in;
      out_dec_ff  <= out_dec_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // status to controller
   assign status.burst      = req_token_end && !stopped_ff &&
                              !(pos_ff == 2'd0 && req_char_byte == CHAR_MINUS);
   assign status.hex_mode   = hex_ff;
   assign status.out_dec    = out_dec_ff;
   assign status.bcd_done   = (bitcnt_ff == BITCNT_LAST);
   assign status.skip_done  = (top_digit != 4'd0) || (ndig_ff == NDIG_W'(1));
   assign status.out_free   = out_free;
   assign status.last_digit = (ndig_ff == NDIG_W'(1));

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;

   // a beat is never loaded over one still waiting
   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("beat loaded while output register busy");

   // stop flag holds until reset
   a_stop_sticky : assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop flag cleared without reset");

   // digit emission never runs past the digit count
   a_ndig_live : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_sel == EMIT_DIGIT) |-> (ndig_ff != '0))
      else $error("digit emitted with empty digit count");

endmodule

[hw/rtl/adhc_ctrl.sv]
// ----------------------------------------------------------------------------
// adhc_ctrl
// Controller of the converter: takes characters, then at a token end runs
// load, binary-to-BCD conversion for hex tokens, leading zero skip and the output burst.
// ----------------------------------------------------------------------------
module adhc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  adhc_pkg::adhc_status_type status,
   output adhc_pkg::adhc_cmd_type    cmd
);
   import adhc_pkg::*;

   adhc_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.burst) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = status.hex_mode ? ST_BCD : ST_SKIP;
         ST_BCD: begin
            if (status.bcd_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.skip_done) begin
               state_in = status.out_dec ? ST_DIGIT : ST_PFX0;
            end
         end
         ST_PFX0: begin
            if (status.out_free) begin
               state_in = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (status.out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free && status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.emit_sel = EMIT_DIGIT;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.step  = req_valid;
         end
         ST_LOAD:  cmd.load = 1'b1;
         ST_BCD:   cmd.bcd_step = 1'b1;
         ST_SKIP:  cmd.skip = !status.skip_done;
         ST_PFX0: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = EMIT_ZERO;
         end
         ST_PFXX: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = EMIT_X;
         end
         ST_DIGIT: cmd.emit = status.out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // characters are only taken between bursts
   a_step_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (state_ff == ST_IDLE && !cmd.emit))
      else $error("character taken during a burst");

endmodule

[hw/rtl/ascii_dec_hex_converter_unit.sv]
// ----------------------------------------------------------------------------
// ascii_dec_hex_converter_unit
// Converts ASCII number tokens between decimal and hexadecimal.
// ----------------------------------------------------------------------------
// Characters of a token arrive one beat per cycle while the input is not
// stalled and are accumulated at once; a token whose second character is 'x'
// is read as hex and answered in unsigned decimal, any other token is
// answered as "0x" plus uppercase hex. A token starting with '-' silences
// the unit until reset. At a token end the input stalls while the result is
// produced: a load step, then for a decimal answer the shift-add-3
// conversion, then dropping of up to 9 leading zero digits and a step to
// leave that phase, then one output beat per cycle (1 to 10 beats) as fast
// as the receiver takes them.
// The last beat of a burst may wait in the output register while the next
// token is already being taken.
// ----------------------------------------------------------------------------
module ascii_dec_hex_converter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_token_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);
   import adhc_pkg::*;

   adhc_cmd_type    cmd;
   adhc_status_type status;

   // sequencing
   adhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and output register
   adhc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_char_byte (req_char_byte),
      .req_token_end (req_token_end),
      .rsp_valid     (rsp_valid),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_last  (rsp_out_last),
      .rsp_stall     (rsp_stall)
   );

endmodule

[bench/ascii_dec_hex_converter_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_dec_hex_converter_unit_tb
// Self-checking bench for the ASCII decimal/hex number converter.
// ----------------------------------------------------------------------------
// Characters are fed one beat at a time on the request channel. A predictor
// tracks the token state and queues the characters of every converted number.
// Each response beat is compared with the oldest queued character. Directed
// tokens hit the edge cases, random tokens run under three idling mixes, and
// the minus token that silences the unit is saved for the very end.
// ----------------------------------------------------------------------------
module ascii_dec_hex_converter_unit_tb;
   import adhc_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 500_000;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned TOK_MAX      = 16;
   localparam int unsigned DRAIN_CYCLES = 64;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_beat_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'd0;
   logic       req_token_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_out_last;

   // predictor copy of the token state
   logic [31:0] tok_value = 32'd0;
   logic [1:0]  tok_pos   = 2'd0;
   logic        tok_hex   = 1'b0;
   logic        halted    = 1'b0;

   out_beat_type expected_chars[$];

   logic [7:0]  tok_buf[TOK_MAX];
   int unsigned tok_len;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count   = 0;
   int unsigned err_count     = 0;
   int unsigned chars_sent    = 0;
   int unsigned tokens_sent   = 0;
   int unsigned beats_checked = 0;

   string hex_digits = "0123456789ABCDEF";

   ascii_dec_hex_converter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .req_token_end (req_token_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_last  (rsp_out_last)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, expected_chars.size());
         $display("ascii_dec_hex_converter_unit_tb failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // compare each response beat with the oldest expected character
   always @(posedge clock) begin
      out_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_chars.size() == 0) begin
            note_error($sformatf("unexpected beat char=%02h last=%b",
                                 rsp_out_char, rsp_out_last));
         end else begin
            want = expected_chars.pop_front();
            beats_checked++;
            if (rsp_out_char !== want.ch || rsp_out_last !== want.last) begin
               note_error($sformatf("char exp %02h got %02h, last exp %b got %b",
                                    want.ch, rsp_out_char, want.last, rsp_out_last));
            end
         end
      end
   end

   task automatic clear_token();
      tok_value = 32'd0;
      tok_pos   = 2'd0;
      tok_hex   = 1'b0;
   endtask

   // append one expected beat at the tail of the queue
   task automatic queue_beat(input logic [7:0] ch, input logic last);
      out_beat_type beat;
      beat.ch   = ch;
      beat.last = last;
      expected_chars.insert(expected_chars.size(), beat);
   endtask

   // fold one accepted character into the token and queue the converted number
   task automatic convert_char(input logic [7:0] c, input logic last_char);
      logic [31:0] cv;
      logic [31:0] radix;
      logic [31:0] rest;
      logic [3:0]  digs[10];
      int          cnt;
      cv = {24'd0, c};
      if (halted) return;
      case (tok_pos)
         2'd0: begin
            if (c == CHAR_MINUS) begin
               halted = 1'b1;
               clear_token();
               return;
            end
            tok_value = cv - DEC_OFFSET;
            tok_pos   = 2'd1;
         end
         2'd1: begin
            if (c == CHAR_X) begin
               tok_hex   = 1'b1;
               tok_value = 32'd0;
            end else begin
               tok_value = tok_value * 32'd10 + (cv - DEC_OFFSET);
            end
            tok_pos = 2'd2;
         end
         default: begin
            if (tok_hex) begin
               tok_value = tok_value * 32'd16 +
                           ((c >= CHAR_UPPER) ? cv - HEX_OFFSET : cv - DEC_OFFSET);
            end else begin
               tok_value = tok_value * 32'd10 + (cv - DEC_OFFSET);
            end
         end
      endcase
      if (!last_char) return;

      // extract digits of the other base, least significant first
      radix = tok_hex ? 32'd10 : 32'd16;
      rest  = tok_value;
      cnt   = 0;
      do begin
         digs[cnt] = 4'(rest % radix);
         rest      = rest / radix;
         cnt++;
      end while (rest != 0 && cnt < 10);

      if (!tok_hex) begin
         queue_beat(CHAR_ZERO, 1'b0);
         queue_beat(CHAR_X, 1'b0);
      end
      for (int i = cnt - 1; i >= 0; i--) begin
         queue_beat((digs[i] <= 4'd9) ? CHAR_ZERO + 8'(digs[i]) :
                                        CHAR_UPPER + 8'(digs[i]) - 8'd10,
                    i == 0);
      end
      clear_token();
   endtask

   // present one character beat, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] c, input logic last_char);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      req_token_end <= last_char;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      if (!halted) chars_sent++;
      convert_char(c, last_char);
   endtask

   task automatic send_token();
      for (int i = 0; i < tok_len; i++) begin
         send_char(tok_buf[i], i == tok_len - 1);
      end
      tokens_sent++;
   endtask

   task automatic send_text(input string s);
      tok_len = s.len();
      for (int i = 0; i < tok_len; i++) begin
         tok_buf[i] = s[i];
      end
      send_token();
   endtask

   // hold the request side idle until every queued character has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic build_random_token();
      int unsigned kind;
      int unsigned ndig;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         // decimal, now and then long enough to wrap
         tok_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 13) :
                                                 $urandom_range(1, 10);
         for (int i = 0; i < tok_len; i++) begin
            tok_buf[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
         end
      end else if (kind < 80) begin
         // hex with prefix, sometimes odd leading char or wrapping length
         ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) :
                                              $urandom_range(0, 8);
         tok_len    = ndig + 2;
         tok_buf[0] = ($urandom_range(0, 3) == 0) ? CHAR_ZERO + 8'($urandom_range(1, 9)) :
                                                    CHAR_ZERO;
         tok_buf[1] = CHAR_X;
         for (int i = 2; i < tok_len; i++) begin
            tok_buf[i] = hex_digits[$urandom_range(0, 15)];
         end
      end else begin
         // arbitrary bytes
         tok_len = $urandom_range(1, 12);
         for (int i = 0; i < tok_len; i++) begin
            tok_buf[i] = 8'($urandom_range(0, 255));
         end
         if (tok_len >= 2 && $urandom_range(0, 1) == 1) tok_buf[1] = CHAR_X;
         if (tok_buf[0] == CHAR_MINUS) tok_buf[0] = CHAR_MINUS + 8'd1;
      end
   endtask

   // zero, single characters and the bare prefix
   task automatic test_short_tokens();
      send_text("0");
      send_text("7");
      send_text("0x");
      send_text("5x1");
   endtask

   // bytes far outside the digit range
   task automatic test_wild_bytes();
      tok_len    = 2;
      tok_buf[0] = 8'h00;
      tok_buf[1] = 8'hFF;
      send_token();
      send_text("0x:a");
   endtask

   // largest hex value gives the longest decimal answer
   task automatic test_widest_value();
      send_text("0xFFFFFFFF");
   endtask

   task automatic test_random_tokens(input int unsigned items,
                                     input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
      int unsigned start;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      start         = chars_sent;
      while (chars_sent - start < items) begin
         build_random_token();
         send_token();
      end
   endtask

   // minus token silences the unit, later tokens must give nothing
   task automatic test_stop_flag();
      send_text("-7");
      send_text("0x1F");
      send_text("9");
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 51;
      test_short_tokens();
      test_wild_bytes();
      test_widest_value();

      test_random_tokens(170, 21, 51);
      drain_results();
      test_random_tokens(170, 51, 21);
      test_random_tokens(170, 0, 0);
      test_stop_flag();

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d characters in %0d tokens, checked %0d result beats",
               chars_sent, tokens_sent, beats_checked);
      $display("decimal, hex, prefix-only, wild-byte and stop tokens, %0d mismatches",
               err_count);
      if (err_count == 0 && expected_chars.size() == 0) begin
         $display("ascii_dec_hex_converter_unit_tb passed");
      end else begin
         if (expected_chars.size() != 0) begin
            $display("%0d expected beats never arrived", expected_chars.size());
         end
         $display("ascii_dec_hex_converter_unit_tb failed");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/adhc_pkg.sv
hw/rtl/adhc_datapath.sv
hw/rtl/adhc_ctrl.sv
hw/rtl/ascii_dec_hex_converter_unit.sv
bench/ascii_dec_hex_converter_unit_tb.sv
